### design/gcrd_pkg.sv
// Shared types and constants for the ramped drive block.
// Used by the channel interfaces, controller, datapath and top level.
package gcrd_pkg;

  // field widths
  localparam int COUNT_W  = 21;
  localparam int HEAD_W   = 16;
  localparam int TIME_W   = 16;
  localparam int TARGET_W = 20;
  localparam int PWR_W    = 7;
  localparam int GAIN_W   = 16;
  localparam int FRAC_W   = 9;
  localparam int DIR_W    = 2;
  localparam int OUT_W    = 8;

  // configuration port
  localparam int IDX_W = 3;
  localparam int CFG_W = 20;

  localparam logic [IDX_W-1:0] REG_DIRECTION      = 3'd0;
  localparam logic [IDX_W-1:0] REG_TARGET_COUNT   = 3'd1;
  localparam logic [IDX_W-1:0] REG_TIMEOUT_MS     = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_POWER      = 3'd3;
  localparam logic [IDX_W-1:0] REG_MIN_POWER      = 3'd4;
  localparam logic [IDX_W-1:0] REG_DRIFT_GAIN     = 3'd5;
  localparam logic [IDX_W-1:0] REG_ACCEL_FRACTION = 3'd6;
  localparam logic [IDX_W-1:0] REG_DECEL_FRACTION = 3'd7;

  // register reset values
  localparam logic signed [DIR_W-1:0] DIRECTION_RST = 2'sd1;
  localparam logic [TARGET_W-1:0]     TARGET_RST    = 20'd0;
  localparam logic [TIME_W-1:0]       TIMEOUT_RST   = 16'd5000;
  localparam logic [PWR_W-1:0]        MAX_PWR_RST   = 7'd127;
  localparam logic [PWR_W-1:0]        MIN_PWR_RST   = 7'd0;
  localparam logic [GAIN_W-1:0]       GAIN_RST      = 16'd0;
  localparam logic [FRAC_W-1:0]       ACCEL_RST     = 9'd64;
  localparam logic [FRAC_W-1:0]       DECEL_RST     = 9'd64;

  // input kind codes
  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SEL,
    ST_DIV,
    ST_MUL,
    ST_BASE,
    ST_OUT,
    ST_BRAKE
  } gcrd_state_t;

  typedef struct packed {
    logic load_in;
    logic start_move;
    logic prep;
    logic div_start;
    logic set_one;
    logic take_quo;
    logic mul;
    logic base;
    logic write_result;
    logic write_brake;
  } gcrd_cmd_t;

  typedef struct packed {
    logic kind;
    logic armed;
    logic finished;
    logic use_div;
    logic div_busy;
    logic out_free;
  } gcrd_status_t;

endpackage

### design/gcrd_if.sv
// Valid/ready channel interfaces for sample items and power result items.
// Depends on gcrd_pkg for field widths.
interface gcrd_sample_if;
  import gcrd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic signed [COUNT_W-1:0]  left_count;
  logic signed [COUNT_W-1:0]  right_count;
  logic signed [HEAD_W-1:0]   heading_error;
  logic        [TIME_W-1:0]   elapsed_ms;

  modport source (output valid, kind, left_count, right_count, heading_error, elapsed_ms,
                  input ready);
  modport sink (input valid, kind, left_count, right_count, heading_error, elapsed_ms,
                output ready);
endinterface

interface gcrd_power_if;
  import gcrd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  left_power;
  logic signed [OUT_W-1:0]  right_power;
  logic                     braking;

  modport source (output valid, left_power, right_power, braking, input ready);
  modport sink (input valid, left_power, right_power, braking, output ready);
endinterface

### design/gcrd_div.sv
// Restoring divider for unsigned operands, one quotient bit per cycle.
// Standalone; used by gcrd_dpath for the ramp factor.
module gcrd_div #(
  parameter int NUM_W = 37,
  parameter int DEN_W = 29
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             fits;

  assign rem_sh = {rem, quo[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};
  assign fits   = ~diff[DEN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

### design/gcrd_dpath.sv
// Datapath: configuration registers, move state, ramp arithmetic, output register.
// Depends on gcrd_pkg; instantiates gcrd_div.
module gcrd_dpath #(
  parameter int POWER_LIMIT   = 127,
  parameter int BRAKE_POWER   = 15,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gcrd_pkg::gcrd_cmd_t                 cmd,
  output gcrd_pkg::gcrd_status_t              status,
  input  logic                                cfg_we,
  input  logic [gcrd_pkg::IDX_W-1:0]          cfg_index,
  input  logic [gcrd_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                kind,
  input  logic signed [gcrd_pkg::COUNT_W-1:0] left_count,
  input  logic signed [gcrd_pkg::COUNT_W-1:0] right_count,
  input  logic signed [gcrd_pkg::HEAD_W-1:0]  heading_error,
  input  logic [gcrd_pkg::TIME_W-1:0]         elapsed_ms,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [gcrd_pkg::OUT_W-1:0]   left_power,
  output logic signed [gcrd_pkg::OUT_W-1:0]   right_power,
  output logic                                braking
);
  import gcrd_pkg::*;

  localparam int FB     = FRACTION_BITS;
  localparam int NW     = COUNT_W + 2 * FB;        // dividend / quotient
  localparam int DW     = TARGET_W + FRAC_W;       // target * fraction
  localparam int BW     = NW + 1;                  // signed ramp factor
  localparam int PW     = BW + PWR_W + 1;          // factor * span
  localparam int TW     = PW + 1;                  // sums before truncation
  localparam int CW     = FB + DW + 2;             // ramp compares
  localparam int LW     = $clog2(POWER_LIMIT + 1) + 1;
  localparam int EW     = LW + OUT_W;
  localparam int CORR_W = HEAD_W + GAIN_W + 1;
  localparam int ONE    = 1 << FB;
  localparam int BRK    = (BRAKE_POWER < POWER_LIMIT) ? BRAKE_POWER : POWER_LIMIT;

  localparam logic signed [TW-1:0] TMAX = TW'(POWER_LIMIT);
  localparam logic signed [TW-1:0] TMIN = TW'(-POWER_LIMIT);
  localparam logic signed [LW-1:0] LMAX = LW'(POWER_LIMIT);
  localparam logic signed [LW-1:0] LMIN = LW'(-POWER_LIMIT);
  localparam logic [OUT_W-1:0]     BRK_MAG = OUT_W'(BRK);

  // configuration
  logic signed [DIR_W-1:0] direction;
  logic [TARGET_W-1:0]     target_count;
  logic [TIME_W-1:0]       timeout_ms;
  logic [PWR_W-1:0]        max_power;
  logic [PWR_W-1:0]        min_power;
  logic [GAIN_W-1:0]       drift_gain;
  logic [FRAC_W-1:0]       accel_fraction;
  logic [FRAC_W-1:0]       decel_fraction;

  // move state
  logic                      armed;
  logic signed [COUNT_W-1:0] last_average;
  logic [TIME_W-1:0]         last_elapsed;

  // captured item
  logic                      kind_r;
  logic signed [COUNT_W-1:0] left_r;
  logic signed [COUNT_W-1:0] right_r;
  logic signed [HEAD_W-1:0]  heading_r;
  logic [TIME_W-1:0]         elapsed_r;

  // working registers
  logic signed [COUNT_W-1:0] avg;
  logic [DW-1:0]             acc;
  logic [DW-1:0]             dec;
  logic                      b_neg;
  logic signed [BW-1:0]      b;
  logic signed [PW-1:0]      prod;
  logic signed [CORR_W-1:0]  corr;
  logic signed [LW-1:0]      base;

  // combinational
  logic signed [COUNT_W:0]   cnt_sum;
  logic signed [COUNT_W:0]   cnt_adj;
  logic [COUNT_W-1:0]        last_abs;
  logic signed [CW-1:0]      avg_sc;
  logic signed [CW-1:0]      acc_s;
  logic signed [CW-1:0]      knee;
  logic                      acc_br;
  logic                      dec_br;
  logic signed [COUNT_W:0]   num_val;
  logic signed [COUNT_W:0]   num_mag;
  logic [NW-1:0]             div_num;
  logic [DW-1:0]             div_den;
  logic                      div_busy;
  logic [NW-1:0]             quo;
  logic signed [PWR_W:0]     span;
  logic signed [TW-1:0]      base_sum;
  logic signed [TW-1:0]      left_sum;
  logic signed [TW-1:0]      right_sum;
  logic                      dir_neg;
  logic                      dir_zero;
  logic [OUT_W-1:0]          brake_val;

  // divide by 2^FB toward zero, then clamp to the power limit
  function automatic logic signed [LW-1:0] trunc_sat(input logic signed [TW-1:0] v);
    logic signed [TW-1:0] sh;
    logic signed [TW-1:0] q;
    sh = v >>> FB;
    q  = sh + $signed(TW'(v[TW-1] & (|v[FB-1:0])));
    if (q > TMAX) begin
      return LMAX;
    end else if (q < TMIN) begin
      return LMIN;
    end else begin
      return q[LW-1:0];
    end
  endfunction

  function automatic logic [OUT_W-1:0] apply_dir(input logic signed [LW-1:0] v,
                                                 input logic neg, input logic zero);
    logic signed [EW-1:0] ext;
    logic signed [EW-1:0] res;
    ext = EW'(v);
    if (zero) begin
      res = '0;
    end else if (neg) begin
      res = -ext;
    end else begin
      res = ext;
    end
    return res[OUT_W-1:0];
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      direction      <= DIRECTION_RST;
      target_count   <= TARGET_RST;
      timeout_ms     <= TIMEOUT_RST;
      max_power      <= MAX_PWR_RST;
      min_power      <= MIN_PWR_RST;
      drift_gain     <= GAIN_RST;
      accel_fraction <= ACCEL_RST;
      decel_fraction <= DECEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIRECTION:      direction      <= $signed(cfg_data[DIR_W-1:0]);
        REG_TARGET_COUNT:   target_count   <= cfg_data[TARGET_W-1:0];
        REG_TIMEOUT_MS:     timeout_ms     <= cfg_data[TIME_W-1:0];
        REG_MAX_POWER:      max_power      <= cfg_data[PWR_W-1:0];
        REG_MIN_POWER:      min_power      <= cfg_data[PWR_W-1:0];
        REG_DRIFT_GAIN:     drift_gain     <= cfg_data[GAIN_W-1:0];
        REG_ACCEL_FRACTION: accel_fraction <= cfg_data[FRAC_W-1:0];
        REG_DECEL_FRACTION: decel_fraction <= cfg_data[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // move state
  always_ff @(posedge clk) begin
    if (rst) begin
      armed        <= 1'b0;
      last_average <= '0;
      last_elapsed <= '0;
    end else if (cmd.start_move) begin
      armed        <= 1'b1;
      last_average <= '0;
      last_elapsed <= '0;
    end else if (cmd.write_result) begin
      last_average <= avg;
      last_elapsed <= elapsed_r;
    end else if (cmd.write_brake) begin
      armed <= 1'b0;
    end
  end

  assign last_abs = last_average[COUNT_W-1] ? COUNT_W'(-last_average) : last_average;

  assign status.kind     = kind_r;
  assign status.armed    = armed;
  assign status.finished = (last_abs >= {1'b0, target_count}) || (last_elapsed >= timeout_ms);
  assign status.div_busy = div_busy;
  assign status.out_free = ~out_valid | out_ready;

  // average count, truncated toward zero
  assign cnt_sum = $signed({left_r[COUNT_W-1], left_r}) + $signed({right_r[COUNT_W-1], right_r});
  assign cnt_adj = cnt_sum + $signed({{COUNT_W{1'b0}}, cnt_sum[COUNT_W] & cnt_sum[0]});

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r    <= kind;
      left_r    <= left_count;
      right_r   <= right_count;
      heading_r <= heading_error;
      elapsed_r <= elapsed_ms;
    end
    if (cmd.prep) begin
      avg <= cnt_adj[COUNT_W:1];
      acc <= {{FRAC_W{1'b0}}, target_count} * {{TARGET_W{1'b0}}, accel_fraction};
      dec <= {{FRAC_W{1'b0}}, target_count} * {{TARGET_W{1'b0}}, decel_fraction};
    end
  end

  // ramp segment select
  assign avg_sc  = $signed(CW'(avg)) <<< FB;
  assign acc_s   = $signed(CW'(acc));
  assign knee    = $signed(CW'({target_count, {FB{1'b0}}})) - $signed(CW'(dec));
  assign acc_br  = avg_sc < acc_s;
  assign dec_br  = avg_sc > knee;
  assign status.use_div = acc_br ? (acc != '0) : (dec_br && (dec != '0));

  assign num_val = acc_br ? (COUNT_W + 1)'(avg)
                          : $signed((COUNT_W + 1)'(target_count)) - (COUNT_W + 1)'(avg);
  assign num_mag = num_val[COUNT_W] ? -num_val : num_val;
  assign div_num = {num_mag[COUNT_W-1:0], {(2 * FB){1'b0}}};
  assign div_den = acc_br ? acc : dec;

  gcrd_div #(
    .NUM_W (NW),
    .DEN_W (DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (quo)
  );

  assign span = $signed({1'b0, max_power}) - $signed({1'b0, min_power});

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      b_neg <= num_val[COUNT_W];
    end
    if (cmd.set_one) begin
      b <= BW'(ONE);
    end else if (cmd.take_quo) begin
      b <= b_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end
    if (cmd.mul) begin
      prod <= PW'(b) * PW'(span);
      corr <= CORR_W'(heading_r) * $signed({{(CORR_W - GAIN_W){1'b0}}, drift_gain});
    end
    if (cmd.base) begin
      base <= trunc_sat(base_sum);
    end
  end

  assign base_sum  = $signed(TW'({min_power, {FB{1'b0}}})) + TW'(prod);
  assign left_sum  = ($signed(TW'(base)) <<< FB) + TW'(corr);
  assign right_sum = ($signed(TW'(base)) <<< FB) - TW'(corr);

  assign dir_neg   = direction[DIR_W-1];
  assign dir_zero  = (direction == '0);
  assign brake_val = dir_zero ? '0 : (dir_neg ? BRK_MAG : -BRK_MAG);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write_result || cmd.write_brake) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_result) begin
      left_power  <= $signed(apply_dir(trunc_sat(left_sum), dir_neg, dir_zero));
      right_power <= $signed(apply_dir(trunc_sat(right_sum), dir_neg, dir_zero));
      braking     <= 1'b0;
    end else if (cmd.write_brake) begin
      left_power  <= $signed(brake_val);
      right_power <= $signed(brake_val);
      braking     <= 1'b1;
    end
  end

endmodule

### design/gcrd_ctrl.sv
// Controller state machine: sequences one item through the datapath.
// Depends on gcrd_pkg for state, command and status types.
module gcrd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  gcrd_pkg::gcrd_status_t status,
  output gcrd_pkg::gcrd_cmd_t    cmd
);
  import gcrd_pkg::*;

  gcrd_state_t state;
  gcrd_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_PREP;
        end
      end
      ST_PREP: begin
        if (status.kind == KIND_START) begin
          cmd.start_move = 1'b1;
          state_next     = ST_IDLE;
        end else if (!status.armed) begin
          state_next = ST_IDLE;
        end else if (status.finished) begin
          state_next = ST_BRAKE;
        end else begin
          cmd.prep   = 1'b1;
          state_next = ST_SEL;
        end
      end
      ST_SEL: begin
        if (status.use_div) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          cmd.set_one = 1'b1;
          state_next  = ST_MUL;
        end
      end
      ST_DIV: begin
        if (!status.div_busy) begin
          cmd.take_quo = 1'b1;
          state_next   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_BASE;
      end
      ST_BASE: begin
        cmd.base   = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.write_result = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      ST_BRAKE: begin
        if (status.out_free) begin
          cmd.write_brake = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### design/gyro_corrected_ramped_drive.sv
// Top level of the ramped straight drive with heading correction.
// Depends on gcrd_pkg and gcrd_if; instantiates gcrd_ctrl and gcrd_dpath.
//
// A start item (kind 0) arms a move and gives no result. Each sample item
// (kind 1) while armed gives one result: left/right powers that follow a
// trapezoidal ramp over the average encoder count (left+right)/2, with the
// gyro heading correction added on the left and subtracted on the right,
// signed by the direction register and held to +-POWER_LIMIT. Once the
// previous sample's average reached target_count or its time reached
// timeout_ms, the next sample gives a single brake result (braking=1) and
// disarms; samples while disarmed give nothing. Fractions are in units of
// 1/2^FRACTION_BITS and divisions truncate toward zero.
// Items are handled one at a time. A ramp sample that needs the division waits
// on the restoring divider, which yields one quotient bit per cycle; a
// sample on a flat part of the ramp, a brake sample and a start item skip
// the divider. The result sits in an output register, so the next item is
// accepted while a result waits to be taken; only the cycle that writes
// the next result waits for that register to drain.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
module gyro_corrected_ramped_drive #(
  parameter int POWER_LIMIT   = 127,
  parameter int BRAKE_POWER   = 15,
  parameter int FRACTION_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  gcrd_sample_if.sink                sample,
  gcrd_power_if.source               power,
  input  logic                       cfg_we,
  input  logic [gcrd_pkg::IDX_W-1:0] cfg_index,
  input  logic [gcrd_pkg::CFG_W-1:0] cfg_data
);
  import gcrd_pkg::*;

  gcrd_cmd_t    cmd;
  gcrd_status_t status;
  logic         in_ready;

  assign sample.ready = in_ready;

  // sequencing: accept, decide, divide, scale, write
  gcrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic, move state, config and the result register
  gcrd_dpath #(
    .POWER_LIMIT   (POWER_LIMIT),
    .BRAKE_POWER   (BRAKE_POWER),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .kind          (sample.kind),
    .left_count    (sample.left_count),
    .right_count   (sample.right_count),
    .heading_error (sample.heading_error),
    .elapsed_ms    (sample.elapsed_ms),
    .out_ready     (power.ready),
    .out_valid     (power.valid),
    .left_power    (power.left_power),
    .right_power   (power.right_power),
    .braking       (power.braking)
  );

endmodule

### sim/tb_gyro_corrected_ramped_drive.sv
// Self-checking regression for gyro_corrected_ramped_drive: directed ramp and brake
// cases, then randomized moves under random handshake idling and output back-pressure.
// Depends on gcrd_pkg and the gcrd_sample_if / gcrd_power_if channel interfaces.
module tb_gyro_corrected_ramped_drive;
  timeunit 1ns;
  timeprecision 1ps;
  import gcrd_pkg::*;

  localparam int     POWER_LIMIT   = 127;
  localparam int     BRAKE_POWER   = 15;
  localparam int     FRACTION_BITS = 8;
  localparam longint ONE           = longint'(1) << FRACTION_BITS;
  // slowest item is a divider sample; pad its time for the tail wait
  localparam int     SETTLE_CYCLES = 2 * FRACTION_BITS + 28 + 20;
  localparam int     CYCLE_LIMIT   = 600000;
  localparam int     RANDOM_ITEMS  = 1450;
  localparam int     COUNT_MAX     = 1048575;
  localparam int     COUNT_MIN     = -1048576;

  typedef struct packed {
    logic signed [OUT_W-1:0] left_power;
    logic signed [OUT_W-1:0] right_power;
    logic                    braking;
  } power_item_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] direction;
    logic [TARGET_W-1:0]     target_count;
    logic [TIME_W-1:0]       timeout_ms;
    logic [PWR_W-1:0]        max_power;
    logic [PWR_W-1:0]        min_power;
    logic [GAIN_W-1:0]       drift_gain;
    logic [FRAC_W-1:0]       accel_fraction;
    logic [FRAC_W-1:0]       decel_fraction;
  } drive_cfg_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  gcrd_sample_if sample_ch();
  gcrd_power_if  power_ch();

  gyro_corrected_ramped_drive #(
    .POWER_LIMIT  (POWER_LIMIT),
    .BRAKE_POWER  (BRAKE_POWER),
    .FRACTION_BITS(FRACTION_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample_ch),
    .power    (power_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Predictor state: register copy plus the move tracker the block keeps.
  drive_cfg_t                cfg_model;
  bit                        move_armed;
  logic signed [COUNT_W-1:0] prev_average;
  logic [TIME_W-1:0]         prev_elapsed;

  power_item_t power_expected[$];
  int          fail_count;
  int          live_items;     // input items taken so far
  bit          no_idle;        // both sides run back to back while set
  int          hold_request;   // long receiver hold-off, in cycles
  int          cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic longint clamp_power(input longint x);
    if (x > POWER_LIMIT) return POWER_LIMIT;
    if (x < -POWER_LIMIT) return -POWER_LIMIT;
    return x;
  endfunction

  // Trapezoid factor in Q FRACTION_BITS. Negative averages and averages past
  // the target fall out as negative factors (full factor when the span is zero) and get saturated later.
  function automatic longint ramp_gain(input longint avg);
    longint tgt, acc_span, dec_span;
    tgt      = cfg_model.target_count;
    acc_span = cfg_model.accel_fraction;
    dec_span = cfg_model.decel_fraction;
    acc_span = acc_span * tgt;
    dec_span = dec_span * tgt;
    if (avg * ONE < acc_span) begin
      return (acc_span != 0) ? (avg * ONE * ONE) / acc_span : ONE;
    end
    if (avg * ONE > tgt * ONE - dec_span) begin
      return (dec_span != 0) ? ((tgt - avg) * ONE * ONE) / dec_span : ONE;
    end
    return ONE;
  endfunction

  // Advances the move tracker by one accepted item; returns 1 when the item
  // produces a power item, which is left in res.
  function automatic bit drive_step(input logic kind,
                                    input logic signed [COUNT_W-1:0] lc,
                                    input logic signed [COUNT_W-1:0] rc,
                                    input logic signed [HEAD_W-1:0] heading,
                                    input logic [TIME_W-1:0] ms,
                                    output power_item_t res);
    longint dir_sign, avg, factor, base, corr, lp, rp, mag, lo, hi, lim, tmo, tmp;
    res = '0;
    if (kind == KIND_START) begin
      move_armed   = 1'b1;
      prev_average = '0;
      prev_elapsed = '0;
      return 1'b0;
    end
    if (!move_armed) return 1'b0;

    dir_sign = $signed(cfg_model.direction);
    dir_sign = (dir_sign < 0) ? -1 : ((dir_sign > 0) ? 1 : 0);

    // end of move is judged on the previous sample, not this one
    mag = prev_average;
    if (mag < 0) mag = -mag;
    lim = cfg_model.target_count;
    tmo = cfg_model.timeout_ms;
    tmp = prev_elapsed;
    if (mag >= lim || tmp >= tmo) begin
      base             = clamp_power(-dir_sign * BRAKE_POWER);
      move_armed       = 1'b0;
      res.left_power   = base[OUT_W-1:0];
      res.right_power  = base[OUT_W-1:0];
      res.braking      = 1'b1;
      return 1'b1;
    end

    tmp    = lc;
    avg    = rc;
    avg    = (tmp + avg) / 2;
    factor = ramp_gain(avg);
    lo     = cfg_model.min_power;
    hi     = cfg_model.max_power;
    base   = clamp_power((lo * ONE + factor * (hi - lo)) / ONE);
    corr   = heading;
    tmp    = cfg_model.drift_gain;
    corr   = corr * tmp;
    lp     = clamp_power((base * ONE + corr) / ONE) * dir_sign;
    rp     = clamp_power((base * ONE - corr) / ONE) * dir_sign;

    prev_average    = avg[COUNT_W-1:0];
    prev_elapsed    = ms;
    res.left_power  = lp[OUT_W-1:0];
    res.right_power = rp[OUT_W-1:0];
    res.braking     = 1'b0;
    return 1'b1;
  endfunction

  // Every accepted input item goes through the predictor at its accept edge.
  always @(posedge clk) begin : watch_samples
    power_item_t res;
    if (!rst && sample_ch.valid && sample_ch.ready) begin
      live_items++;
      if (drive_step(sample_ch.kind, sample_ch.left_count, sample_ch.right_count,
                     sample_ch.heading_error, sample_ch.elapsed_ms, res)) begin
        power_expected.push_back(res);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  // print cap keeps a badly broken block from flooding the log
  task automatic flag_mismatch(input string field, input longint want, input longint got);
    fail_count++;
    if (fail_count <= 100) $error("%s mismatch: expected %0d, actual %0d", field, want, got);
  endtask

  always @(posedge clk) begin : check_power
    power_item_t want;
    if (!rst && power_ch.valid && power_ch.ready) begin
      if (power_expected.size() == 0) begin
        flag_mismatch("unexpected item, left_power", 0, power_ch.left_power);
      end else begin
        want = power_expected.pop_front();
        if (power_ch.left_power !== want.left_power)
          flag_mismatch("left_power", want.left_power, power_ch.left_power);
        if (power_ch.right_power !== want.right_power)
          flag_mismatch("right_power", want.right_power, power_ch.right_power);
        if (power_ch.braking !== want.braking)
          flag_mismatch("braking", want.braking, power_ch.braking);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random idling per item, plus an optional long hold-off that the
  // back-pressure test asks for. The hold is counted here, not in the test.
  // ---------------------------------------------------------------------------
  initial begin : power_sink
    int gap;
    power_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request > 0) begin
        power_ch.ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        power_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      power_ch.ready <= 1'b1;
      do @(posedge clk);
      while (!(power_ch.valid && power_ch.ready) && hold_request == 0);
    end
  end

  // Run limit: far above the slowest legal run (every item a divider sample,
  // every side idling its longest, plus the hold-off and the phase pauses).
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("gyro_corrected_ramped_drive regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offers one item after a random gap and returns at its accept edge. With a
  // zero gap valid simply stays high, so back-to-back items get no bubble.
  task automatic send_item(input logic kind, input int lc, input int rc,
                           input int hd, input int ms);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.kind          <= kind;
    sample_ch.left_count    <= lc[COUNT_W-1:0];
    sample_ch.right_count   <= rc[COUNT_W-1:0];
    sample_ch.heading_error <= hd[HEAD_W-1:0];
    sample_ch.elapsed_ms    <= ms[TIME_W-1:0];
    do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
  endtask

  // Drops valid, waits for every expected item, then gives a start or an
  // ignored sample still in the block time to finish before a register write.
  task automatic settle();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (power_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Writes all eight registers, only ever called with the block idle.
  task automatic apply_cfg(input drive_cfg_t c);
    reg_write(REG_DIRECTION, {{(CFG_W-DIR_W){1'b0}}, c.direction});
    reg_write(REG_TARGET_COUNT, CFG_W'(c.target_count));
    reg_write(REG_TIMEOUT_MS, CFG_W'(c.timeout_ms));
    reg_write(REG_MAX_POWER, CFG_W'(c.max_power));
    reg_write(REG_MIN_POWER, CFG_W'(c.min_power));
    reg_write(REG_DRIFT_GAIN, CFG_W'(c.drift_gain));
    reg_write(REG_ACCEL_FRACTION, CFG_W'(c.accel_fraction));
    reg_write(REG_DECEL_FRACTION, CFG_W'(c.decel_fraction));
    cfg_we    <= 1'b0;
    cfg_model  = c;
  endtask

  function automatic drive_cfg_t cfg_of(input int dir, input int tgt, input int tmo,
                                        input int hi, input int lo, input int gain,
                                        input int acc, input int dec);
    drive_cfg_t c;
    c.direction      = dir[DIR_W-1:0];
    c.target_count   = tgt[TARGET_W-1:0];
    c.timeout_ms     = tmo[TIME_W-1:0];
    c.max_power      = hi[PWR_W-1:0];
    c.min_power      = lo[PWR_W-1:0];
    c.drift_gain     = gain[GAIN_W-1:0];
    c.accel_fraction = acc[FRAC_W-1:0];
    c.decel_fraction = dec[FRAC_W-1:0];
    return c;
  endfunction

  // Mostly small targets and short timeouts so moves end by both causes;
  // every direction code including the -2 encoding comes up.
  function automatic drive_cfg_t random_cfg();
    drive_cfg_t c;
    c.direction      = DIR_W'($urandom_range(0, 3));
    c.target_count   = TARGET_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, COUNT_MAX)
                                                             : $urandom_range(0, 5000));
    c.timeout_ms     = TIME_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(100, 800));
    c.max_power      = PWR_W'($urandom_range(0, 127));
    c.min_power      = PWR_W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 127)
                                                          : $urandom_range(0, 40));
    c.drift_gain     = GAIN_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, 1024));
    c.accel_fraction = FRAC_W'($urandom_range(0, 256));
    c.decel_fraction = FRAC_W'($urandom_range(0, 256));
    return c;
  endfunction

  // One well-formed move: start, then samples walking the average up past the
  // target with rising time, so the ramp is crossed and the move brakes.
  // Now and then the move is abandoned part way.
  task automatic run_move(input int legs);
    int stride, pos, ms, hd, spread;
    stride = int'(cfg_model.target_count) / legs + 1;
    pos    = 0;
    ms     = 0;
    send_item(KIND_START, 0, 0, 0, 0);
    for (int k = 0; k < legs + 2; k++) begin
      if ($urandom_range(0, 39) == 0) break;
      pos = pos + stride + int'($urandom_range(0, stride / 4));
      if (pos > COUNT_MAX - 32) pos = COUNT_MAX - 32;
      spread = int'($urandom_range(0, 64)) - 32;
      hd = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                       : int'($urandom_range(0, 400)) - 200;
      ms = ms + int'($urandom_range(5, 40));
      if (ms > 65535) ms = 65535;
      send_item(KIND_SAMPLE, pos + spread, pos - spread, hd, ms);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values: target is zero, so an armed sample brakes at once.
  task automatic test_reset_values();
    send_item(KIND_SAMPLE, 5, 7, 0, 0);      // idle, no item
    send_item(KIND_START, 0, 0, 0, 0);
    send_item(KIND_SAMPLE, 0, 0, 0, 0);      // brake, disarm
    send_item(KIND_SAMPLE, 1, 1, 0, 0);      // disarmed again
  endtask

  // Acceleration, flat and deceleration regions, heading saturation both ways,
  // negative average and overshoot past the target.
  task automatic test_ramp_regions();
    settle();
    apply_cfg(cfg_of(1, 1000, 65535, 120, 10, 256, 64, 64));
    send_item(KIND_START, 0, 0, 0, 0);
    send_item(KIND_SAMPLE, 0, 0, 0, 0);
    send_item(KIND_SAMPLE, 100, 140, -5, 20);
    send_item(KIND_SAMPLE, 500, 500, 32767, 40);
    send_item(KIND_SAMPLE, 900, 920, -32768, 60);
    send_item(KIND_SAMPLE, COUNT_MIN, COUNT_MIN, 0, 80);
    send_item(KIND_SAMPLE, 0, 0, 0, 100);    // previous |avg| past target
    send_item(KIND_START, 0, 0, 0, 0);
    send_item(KIND_SAMPLE, COUNT_MAX, COUNT_MAX, 0, 65535);
    send_item(KIND_SAMPLE, 0, 0, 0, 0);      // both end conditions hold
  endtask

  task automatic test_special_cases();
    // empty ramps: zero accel and decel spans give full factor on both sides
    settle();
    apply_cfg(cfg_of(1, 500, 65535, 90, 30, 0, 0, 0));
    send_item(KIND_START, 0, 0, 0, 0);
    send_item(KIND_SAMPLE, -10, -20, 0, 10);
    send_item(KIND_SAMPLE, 600, 600, 0, 20);
    // -2 encoding acts as reverse; min above max; largest gain; timeout brake
    settle();
    apply_cfg(cfg_of(-2, 2000, 30, 30, 100, 65535, 128, 128));
    send_item(KIND_START, 0, 0, 0, 0);
    send_item(KIND_SAMPLE, 300, 300, 3, 40);
    send_item(KIND_SAMPLE, 320, 320, 0, 60);
    // direction zero: every power zero, brake included; full ramp fractions
    settle();
    apply_cfg(cfg_of(0, COUNT_MAX, 15, 127, 0, 512, 256, 256));
    send_item(KIND_START, 0, 0, 0, 0);
    send_item(KIND_SAMPLE, 400, 400, 50, 10);
    send_item(KIND_SAMPLE, 900, 900, 0, 20);
    send_item(KIND_SAMPLE, 0, 0, 0, 0);
    // zero target and timeout with max power zero: brake on the first sample
    settle();
    apply_cfg(cfg_of(-1, 0, 0, 0, 127, 65535, 0, 256));
    send_item(KIND_START, 0, 0, 0, 0);
    send_item(KIND_SAMPLE, COUNT_MAX, COUNT_MIN, 1, 0);
  endtask

  // Random phases, each with its own register set. Mostly whole moves; the
  // rest is full-range noise (stray starts and samples).
  task automatic test_random_moves();
    int base_count, phase_end, phase;
    base_count = live_items;
    phase      = 0;
    while (live_items - base_count < RANDOM_ITEMS) begin
      settle();
      apply_cfg(random_cfg());
      no_idle   = (phase % 4 == 3);
      phase_end = live_items + 110;
      while (live_items < phase_end) begin
        run_move($urandom_range(3, 30));
        if ($urandom_range(0, 3) == 0) begin
          send_item(1'($urandom_range(0, 1)),
                    int'($urandom_range(0, 2097151)) + COUNT_MIN,
                    int'($urandom_range(0, 2097151)) + COUNT_MIN,
                    int'($urandom_range(0, 65535)) - 32768,
                    $urandom_range(0, 65535));
        end
      end
      phase++;
    end
    no_idle = 1'b0;
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // items back to back: the output register fills and the input stalls.
  task automatic test_backpressure();
    settle();
    apply_cfg(cfg_of(1, 4000, 65535, 127, 10, 128, 64, 64));
    no_idle      = 1'b1;
    hold_request = 300;
    run_move(30);
    no_idle      = 1'b0;
  endtask

  initial begin
    rst                     <= 1'b1;
    cfg_we                  <= 1'b0;
    cfg_index               <= '0;
    cfg_data                <= '0;
    sample_ch.valid         <= 1'b0;
    sample_ch.kind          <= KIND_START;
    sample_ch.left_count    <= '0;
    sample_ch.right_count   <= '0;
    sample_ch.heading_error <= '0;
    sample_ch.elapsed_ms    <= '0;
    cfg_model    = '{DIRECTION_RST, TARGET_RST, TIMEOUT_RST, MAX_PWR_RST,
                     MIN_PWR_RST, GAIN_RST, ACCEL_RST, DECEL_RST};
    move_armed   = 1'b0;
    prev_average = '0;
    prev_elapsed = '0;
    fail_count   = 0;
    live_items   = 0;
    no_idle      = 1'b0;
    hold_request = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_ramp_regions();
    test_special_cases();
    test_random_moves();
    test_backpressure();
    settle();

    if (fail_count == 0) begin
      $display("gyro_corrected_ramped_drive regression: pass");
    end else begin
      $display("gyro_corrected_ramped_drive regression: fail");
    end
    $finish;
  end

endmodule
